>>> rtl/sqve_pkg.sv
package sqve_pkg;

    // Command codes of the input item
    localparam logic [1:0] MODE_START    = 2'd0;
    localparam logic [1:0] MODE_PLAIN    = 2'd1;
    localparam logic [1:0] MODE_TEXTURED = 2'd2;

    // Overflow codes of a result item
    localparam logic [1:0] OVF_NONE  = 2'd0;
    localparam logic [1:0] OVF_SLOTS = 2'd1;
    localparam logic [1:0] OVF_BATCH = 2'd2;

    localparam logic [1:0] CORNER_LAST = 2'd3;

    localparam int unsigned SQVE_NUM_SLOTS = 16;
    localparam logic [16:0] MAX_QUADS_RESET = 17'd4096;
    localparam logic [16:0] MAX_QUADS_CAP   = 17'd65536;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RESOLVE,
        ST_EMIT
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load;     // latch an accepted quad item
        logic clear;    // start a new batch
        logic check;    // slot compare and batch limit check
        logic resolve;  // pick slot, bump counters, set overflow code
        logic advance;  // step to the next corner
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_start;
        logic in_quad;
        logic emit_last;
    } t_status;

    // Saturate a 33-bit signed sum to 32 bits
    function automatic logic [31:0] sat33(input logic [32:0] s);
        logic [31:0] r;
        if (s[32] != s[31]) begin
            r = s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/sqve_ctrl.sv
module sqve_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic             i_stall,
    input  sqve_pkg::t_status i_status,
    output sqve_pkg::t_cmd   o_cmd,
    output logic             o_stall,
    output logic             o_valid
);

    sqve_pkg::t_state r_state;
    sqve_pkg::t_state n_state;
    logic             in_accept;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sqve_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign in_accept = i_valid && (r_state == sqve_pkg::ST_IDLE);

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_stall = 1'b1;
        o_valid = 1'b0;
        unique case (r_state)
            sqve_pkg::ST_IDLE: begin
                o_stall = 1'b0;
                if (in_accept) begin
                    o_cmd.clear = i_status.in_start;
                    o_cmd.load  = i_status.in_quad;
                    if (i_status.in_quad) begin
                        n_state = sqve_pkg::ST_CHECK;
                    end
                end
            end
            sqve_pkg::ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = sqve_pkg::ST_RESOLVE;
            end
            sqve_pkg::ST_RESOLVE: begin
                o_cmd.resolve = 1'b1;
                n_state       = sqve_pkg::ST_EMIT;
            end
            sqve_pkg::ST_EMIT: begin
                o_valid = 1'b1;
                if (!i_stall) begin
                    if (i_status.emit_last) begin
                        n_state = sqve_pkg::ST_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: n_state = sqve_pkg::ST_IDLE;
        endcase
    end

endmodule

>>> rtl/sqve_dp.sv
module sqve_dp #(
    parameter int unsigned NUM_SLOTS = sqve_pkg::SQVE_NUM_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sqve_pkg::t_cmd     i_cmd,
    output sqve_pkg::t_status  o_status,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_data,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_size_x,
    input  logic signed [31:0] i_size_y,
    input  logic [31:0]        i_color_rgba,
    input  logic [31:0]        i_texture_id,
    input  logic [31:0]        i_uv_corner0,
    input  logic [31:0]        i_uv_corner1,
    input  logic [31:0]        i_uv_corner2,
    input  logic [31:0]        i_uv_corner3,
    output logic signed [31:0] o_vertex_x,
    output logic signed [31:0] o_vertex_y,
    output logic signed [31:0] o_vertex_z,
    output logic [31:0]        o_vertex_color,
    output logic [31:0]        o_vertex_uv,
    output logic [3:0]         o_slot_index,
    output logic [1:0]         o_corner,
    output logic               o_last_vertex,
    output logic [18:0]        o_index_total,
    output logic [1:0]         o_overflow
);

    localparam int unsigned SlotW = $clog2(NUM_SLOTS);
    localparam int unsigned UsedW = $clog2(NUM_SLOTS + 1);

    // Configuration and batch state
    logic [16:0]       r_max_quads;
    logic [16:0]       r_quad_count;
    logic [UsedW-1:0]  r_slots_used;
    logic [31:0]       r_slot_ids [NUM_SLOTS];

    // Latched quad item
    logic              r_textured;
    logic [31:0]       r_x0, r_x1, r_y0, r_y1;
    logic [31:0]       r_z;
    logic [31:0]       r_color;
    logic [31:0]       r_tex_id;
    logic [3:0][31:0]  r_uv;

    // Lookup and emit state
    logic [NUM_SLOTS-1:0] r_match;
    logic [NUM_SLOTS-1:0] n_match;
    logic                 r_full;
    logic [SlotW-1:0]     r_slot;
    logic [1:0]           r_corner;
    logic [1:0]           r_ovf;

    logic signed [31:0] half_x, half_y;
    logic [16:0]        limit;
    logic [SlotW-1:0]   hit_slot;
    logic               hit;
    logic               slots_full;
    logic               reject;

    assign o_status.in_start  = (i_mode == sqve_pkg::MODE_START);
    assign o_status.in_quad   = (i_mode == sqve_pkg::MODE_PLAIN) ||
                                (i_mode == sqve_pkg::MODE_TEXTURED);
    assign reject             = (r_ovf != sqve_pkg::OVF_NONE);
    assign o_status.emit_last = reject || (r_corner == sqve_pkg::CORNER_LAST);

    assign half_x = i_size_x >>> 1;
    assign half_y = i_size_y >>> 1;
    assign limit  = (r_max_quads > sqve_pkg::MAX_QUADS_CAP) ?
                    sqve_pkg::MAX_QUADS_CAP : r_max_quads;

    // Hold the limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_quads <= sqve_pkg::MAX_QUADS_RESET;
        end else if (i_cfg_we) begin
            r_max_quads <= i_cfg_data;
        end
    end

    // Latch the quad and form its corner coordinates
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_textured <= (i_mode == sqve_pkg::MODE_TEXTURED);
            r_x0       <= sqve_pkg::sat33({i_pos_x[31], i_pos_x} - {half_x[31], half_x});
            r_x1       <= sqve_pkg::sat33({i_pos_x[31], i_pos_x} + {half_x[31], half_x});
            r_y0       <= sqve_pkg::sat33({i_pos_y[31], i_pos_y} - {half_y[31], half_y});
            r_y1       <= sqve_pkg::sat33({i_pos_y[31], i_pos_y} + {half_y[31], half_y});
            r_z        <= i_pos_z;
            r_color    <= i_color_rgba;
            r_tex_id   <= i_texture_id;
            r_uv       <= {i_uv_corner3, i_uv_corner2, i_uv_corner1, i_uv_corner0};
        end
    end

    // Compare the id against every used slot above the white one
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            n_match[i] = (i != 0) && (UsedW'(i) < r_slots_used) &&
                         (r_slot_ids[i] == r_tex_id);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.check) begin
            r_match <= n_match;
            r_full  <= (r_quad_count >= limit);
        end
    end

    // Take the lowest matching slot
    always_comb begin
        hit_slot = '0;
        for (int i = NUM_SLOTS - 1; i >= 1; i--) begin
            if (r_match[i]) begin
                hit_slot = SlotW'(i);
            end
        end
    end

    assign hit        = |r_match;
    assign slots_full = (r_slots_used == UsedW'(NUM_SLOTS));

    // Clear the batch, resolve the slot, bump counters and step through corners
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quad_count <= '0;
            r_slots_used <= UsedW'(1);
            r_ovf        <= sqve_pkg::OVF_NONE;
            r_corner     <= '0;
            r_slot       <= '0;
        end else if (i_cmd.clear) begin
            r_quad_count <= '0;
            r_slots_used <= UsedW'(1);
        end else if (i_cmd.resolve) begin
            r_corner <= '0;
            r_slot   <= '0;
            if (r_full) begin
                r_ovf <= sqve_pkg::OVF_BATCH;
            end else if (r_textured && !hit && slots_full) begin
                r_ovf <= sqve_pkg::OVF_SLOTS;
            end else begin
                r_ovf        <= sqve_pkg::OVF_NONE;
                r_quad_count <= r_quad_count + 17'd1;
                if (r_textured) begin
                    if (hit) begin
                        r_slot <= hit_slot;
                    end else begin
                        r_slot       <= r_slots_used[SlotW-1:0];
                        r_slots_used <= r_slots_used + UsedW'(1);
                    end
                end
            end
        end else if (i_cmd.advance) begin
            r_corner <= r_corner + 2'd1;
        end
    end

    // Append a new texture id
    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve && !r_full && r_textured && !hit && !slots_full) begin
            r_slot_ids[r_slots_used[SlotW-1:0]] <= r_tex_id;
        end
    end

    // Drive the result item from registers
    always_comb begin
        o_index_total = {r_quad_count, 2'b00} + {1'b0, r_quad_count, 1'b0};
        o_overflow    = r_ovf;
        if (reject) begin
            o_vertex_x     = '0;
            o_vertex_y     = '0;
            o_vertex_z     = '0;
            o_vertex_color = '0;
            o_vertex_uv    = '0;
            o_slot_index   = '0;
            o_corner       = '0;
            o_last_vertex  = 1'b1;
        end else begin
            o_vertex_x     = (r_corner[0] ^ r_corner[1]) ? r_x1 : r_x0;
            o_vertex_y     = r_corner[1] ? r_y1 : r_y0;
            o_vertex_z     = r_z;
            o_vertex_color = r_color;
            o_vertex_uv    = r_textured ? r_uv[r_corner] : '0;
            o_slot_index   = 4'(r_slot);
            o_corner       = r_corner;
            o_last_vertex  = (r_corner == sqve_pkg::CORNER_LAST);
        end
    end

endmodule

>>> rtl/sprite_quad_vertex_expander.sv
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_mode, i_pos_*, i_size_*, i_color_rgba, i_texture_id, i_uv_*
// output    o_valid   i_stall   o_vertex_*, o_slot_index, o_corner, o_last_vertex, ...
// config    i_cfg_we  -         i_cfg_data (max_quads)
//
// A quad goes through accept, slot compare and resolve, then emits its four
// vertices, one per cycle while the output is not stalled. A start command starts a new batch.
// A dropped quad goes through accept, compare and resolve and gives one overflow item.
// The input is stalled while a quad is in flight; output stalls hold the item.
// Synchronous active-low reset: empty batch, slot 0 only, max_quads 4096.
// The slot table itself is not cleared; only slots in use are compared.
module sprite_quad_vertex_expander #(
    parameter int unsigned NUM_SLOTS = sqve_pkg::SQVE_NUM_SLOTS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [16:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_size_x,
    input  logic signed [31:0] i_size_y,
    input  logic [31:0]        i_color_rgba,
    input  logic [31:0]        i_texture_id,
    input  logic [31:0]        i_uv_corner0,
    input  logic [31:0]        i_uv_corner1,
    input  logic [31:0]        i_uv_corner2,
    input  logic [31:0]        i_uv_corner3,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_vertex_x,
    output logic signed [31:0] o_vertex_y,
    output logic signed [31:0] o_vertex_z,
    output logic [31:0]        o_vertex_color,
    output logic [31:0]        o_vertex_uv,
    output logic [3:0]         o_slot_index,
    output logic [1:0]         o_corner,
    output logic               o_last_vertex,
    output logic [18:0]        o_index_total,
    output logic [1:0]         o_overflow
);

    sqve_pkg::t_cmd    cmd;
    sqve_pkg::t_status status;

    sqve_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_stall  (i_stall),
        .i_status (status),
        .o_cmd    (cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid)
    );

    sqve_dp #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_mode         (i_mode),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_pos_z        (i_pos_z),
        .i_size_x       (i_size_x),
        .i_size_y       (i_size_y),
        .i_color_rgba   (i_color_rgba),
        .i_texture_id   (i_texture_id),
        .i_uv_corner0   (i_uv_corner0),
        .i_uv_corner1   (i_uv_corner1),
        .i_uv_corner2   (i_uv_corner2),
        .i_uv_corner3   (i_uv_corner3),
        .o_vertex_x     (o_vertex_x),
        .o_vertex_y     (o_vertex_y),
        .o_vertex_z     (o_vertex_z),
        .o_vertex_color (o_vertex_color),
        .o_vertex_uv    (o_vertex_uv),
        .o_slot_index   (o_slot_index),
        .o_corner       (o_corner),
        .o_last_vertex  (o_last_vertex),
        .o_index_total  (o_index_total),
        .o_overflow     (o_overflow)
    );

    // Never offer a result while taking a new item
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && !o_stall))
        else $error("result offered while input is open");

    // A start command gives no result
    a_start_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && i_mode == sqve_pkg::MODE_START) |=> !o_valid)
        else $error("start command produced a result");

    // The last item of a quad reopens the input
    a_reopen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_vertex) |=> !o_stall)
        else $error("input not reopened after last item");

    // Last flag only on the fourth corner or on an overflow item
    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_vertex) |->
            (o_corner == sqve_pkg::CORNER_LAST || o_overflow != sqve_pkg::OVF_NONE))
        else $error("last flag on a middle corner");

endmodule
